// File: design/rdq_pkg.sv
`timescale 1ns / 1ps

package rdq_pkg;

  // request kind codes on the input channel
  localparam logic [2:0] KIND_INS_FRONT = 3'd0;
  localparam logic [2:0] KIND_INS_BACK  = 3'd1;
  localparam logic [2:0] KIND_REM_FRONT = 3'd2;
  localparam logic [2:0] KIND_REM_BACK  = 3'd3;
  localparam logic [2:0] KIND_LIST      = 3'd4;
  localparam logic [2:0] KIND_SEARCH    = 3'd5;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  // entries in the command queue between front and back
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
  } rdq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [4:0]         position;
    logic               last;
  } rdq_out_t;

  typedef enum logic [2:0] {
    OP_INS_FRONT,
    OP_INS_BACK,
    OP_REM_FRONT,
    OP_REM_BACK,
    OP_LIST,
    OP_SEARCH
  } rdq_op_t;

  typedef struct packed {
    rdq_op_t     op;
    logic [31:0] value;
  } rdq_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } rdq_state_t;

endpackage

// File: design/rdq_front.sv
`timescale 1ns / 1ps

module rdq_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rdq_pkg::rdq_in_t  in_item,
  output logic              cmd_valid,
  output rdq_pkg::rdq_cmd_t cmd,
  input  logic              cmd_pop
);

  localparam int QAW = $clog2(rdq_pkg::QDEPTH);
  localparam int QCW = $clog2(rdq_pkg::QDEPTH + 1);
  localparam logic [QAW-1:0] QLAST = QAW'(rdq_pkg::QDEPTH - 1);

  rdq_pkg::rdq_cmd_t q_mem_r [rdq_pkg::QDEPTH];
  logic [QAW-1:0]    wptr_r, wptr_nxt;
  logic [QAW-1:0]    rptr_r, rptr_nxt;
  logic [QCW-1:0]    fill_r, fill_nxt;

  rdq_pkg::rdq_op_t  op_dec;
  logic              known;
  logic              push;
  logic              pop;

  always_comb begin
    known  = 1'b1;
    op_dec = rdq_pkg::OP_INS_FRONT;
    unique case (in_item.kind)
      rdq_pkg::KIND_INS_FRONT: op_dec = rdq_pkg::OP_INS_FRONT;
      rdq_pkg::KIND_INS_BACK:  op_dec = rdq_pkg::OP_INS_BACK;
      rdq_pkg::KIND_REM_FRONT: op_dec = rdq_pkg::OP_REM_FRONT;
      rdq_pkg::KIND_REM_BACK:  op_dec = rdq_pkg::OP_REM_BACK;
      rdq_pkg::KIND_LIST:      op_dec = rdq_pkg::OP_LIST;
      rdq_pkg::KIND_SEARCH:    op_dec = rdq_pkg::OP_SEARCH;
      default:                 known  = 1'b0;  // unused kinds are taken and dropped
    endcase
  end

  assign in_stall  = (fill_r == QCW'(rdq_pkg::QDEPTH));
  assign push      = in_valid && !in_stall && known;
  assign cmd_valid = (fill_r != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    fill_nxt = fill_r;
    if (push) begin
      wptr_nxt = (wptr_r == QLAST) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QLAST) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wptr_r] <= '{op: op_dec, value: in_item.value};
    end
  end

endmodule

// File: design/rdq_back.sv
`timescale 1ns / 1ps

module rdq_back #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  rdq_pkg::rdq_cmd_t cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output rdq_pkg::rdq_out_t out_item
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW:0]   DEPTH_W  = (CW+1)'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  rdq_pkg::rdq_state_t   state_r, state_nxt;
  logic [IW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  rdq_pkg::rdq_op_t      op_r, op_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic [IW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]         len_r, len_nxt;
  logic [CW-1:0]         iss_r, iss_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic                  out_valid_r;
  rdq_pkg::rdq_out_t     out_item_r;

  logic                  can_emit;
  logic                  emit;
  rdq_pkg::rdq_out_t     emit_item;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic                  rd_en;
  logic                  start_walk;
  logic                  consume;
  logic                  done;
  logic                  issue;
  logic                  last_ent;
  logic                  match;

  logic [DATA_WIDTH+31:0] key_wide;
  logic [DATA_WIDTH-1:0]  key_in;
  logic [DATA_WIDTH+31:0] data_wide;
  logic [CW+5:0]          pos_wide;
  logic [IW-1:0]          head_dec, head_inc, ptr_inc;
  logic [CW:0]            tail_sum, back_sum;
  logic [IW-1:0]          tail_idx, back_idx;
  logic                   full, empty;

  // ring arithmetic
  assign head_dec = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign ptr_inc  = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
  assign tail_sum = (CW+1)'(head_r) + (CW+1)'(count_r);
  assign back_sum = tail_sum - 1'b1;
  assign tail_idx = (tail_sum >= DEPTH_W) ? IW'(tail_sum - DEPTH_W) : IW'(tail_sum);
  assign back_idx = (back_sum >= DEPTH_W) ? IW'(back_sum - DEPTH_W) : IW'(back_sum);
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);

  assign key_wide  = {{DATA_WIDTH{1'b0}}, cmd.value};
  assign key_in    = key_wide[DATA_WIDTH-1:0];
  assign data_wide = {32'd0, rd_data_r};
  assign pos_wide  = (CW+6)'(idx_r) + 1'b1;
  assign last_ent  = ((idx_r + 1'b1) == len_r);
  assign match     = (rd_data_r == key_r);

  assign can_emit  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    rd_ptr_nxt = rd_ptr_r;
    len_nxt    = len_r;
    iss_nxt    = iss_r;
    idx_nxt    = idx_r;
    rd_vld_nxt = rd_vld_r;
    cmd_pop    = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = head_r;
    rd_en      = 1'b0;
    start_walk = 1'b0;
    consume    = 1'b0;
    done       = 1'b0;
    issue      = 1'b0;
    emit       = 1'b0;
    emit_item  = '{status: rdq_pkg::STAT_OK, data: '0, position: '0, last: 1'b1};

    unique case (state_r)
      rdq_pkg::S_IDLE: begin
        if (cmd_valid && can_emit) begin
          cmd_pop = 1'b1;
          op_nxt  = cmd.op;
          key_nxt = key_in;
          iss_nxt = '0;
          idx_nxt = '0;
          rd_vld_nxt = 1'b0;
          case (cmd.op) inside
            rdq_pkg::OP_INS_FRONT, rdq_pkg::OP_INS_BACK: begin
              emit = 1'b1;
              if (full) begin
                emit_item.status = rdq_pkg::STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
                if (cmd.op == rdq_pkg::OP_INS_FRONT) begin
                  wr_addr  = head_dec;
                  head_nxt = head_dec;
                end else begin
                  wr_addr = tail_idx;
                end
              end
            end
            default: begin
              if (empty) begin
                emit             = 1'b1;
                emit_item.status = rdq_pkg::STAT_EMPTY;
              end else begin
                start_walk = 1'b1;
                case (cmd.op) inside
                  rdq_pkg::OP_REM_FRONT: begin
                    rd_ptr_nxt = head_r;
                    len_nxt    = CW'(1);
                    head_nxt   = head_inc;
                    count_nxt  = count_r - 1'b1;
                  end
                  rdq_pkg::OP_REM_BACK: begin
                    rd_ptr_nxt = back_idx;
                    len_nxt    = CW'(1);
                    count_nxt  = count_r - 1'b1;
                  end
                  default: begin
                    rd_ptr_nxt = head_r;
                    len_nxt    = count_r;
                  end
                endcase
              end
            end
          endcase
        end
      end
      rdq_pkg::S_WALK: begin
        if (rd_vld_r) begin
          if (op_r == rdq_pkg::OP_SEARCH) begin
            if (match || last_ent) begin
              if (can_emit) begin
                consume = 1'b1;
                done    = 1'b1;
                emit    = 1'b1;
                if (match) begin
                  emit_item.position = pos_wide[4:0];
                end else begin
                  emit_item.status = rdq_pkg::STAT_NOT_FOUND;
                end
              end
            end else begin
              consume = 1'b1;  // miss on a middle entry: no result
            end
          end else if (can_emit) begin
            consume        = 1'b1;
            done           = last_ent;
            emit           = 1'b1;
            emit_item.data = data_wide[31:0];
            emit_item.last = last_ent;
            if (op_r == rdq_pkg::OP_LIST) begin
              emit_item.position = pos_wide[4:0];
            end
          end
        end
        // keep one read in flight ahead of the compare / emit
        issue = (iss_r != len_r) && (!rd_vld_r || consume) && !done;
        if (issue) begin
          rd_en      = 1'b1;
          rd_ptr_nxt = ptr_inc;
          iss_nxt    = iss_r + 1'b1;
        end
        if (consume) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (done) begin
          rd_vld_nxt = 1'b0;
        end else if (issue) begin
          rd_vld_nxt = 1'b1;
        end else if (consume) begin
          rd_vld_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rdq_pkg::S_IDLE: if (start_walk) state_nxt = rdq_pkg::S_WALK;
      rdq_pkg::S_WALK: if (done) state_nxt = rdq_pkg::S_IDLE;
      default:         state_nxt = rdq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rdq_pkg::S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      iss_r       <= '0;
      idx_r       <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      iss_r       <= iss_nxt;
      idx_r       <= idx_nxt;
      len_r       <= len_nxt;
      out_valid_r <= emit || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    if (emit) begin
      out_item_r <= emit_item;
    end
  end

  // entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= key_in;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rdq_pkg::S_IDLE |-> !rd_vld_r)
    else $error("read data pending while idle");

  a_walk_track: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rdq_pkg::S_WALK |-> iss_r == (idx_r + CW'(rd_vld_r)))
    else $error("issued reads out of step with consumed entries");

  a_no_emit_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_item_r)))
    else $error("stalled result overwritten");

endmodule

// File: design/ring_deque_with_search_top.sv
`timescale 1ns / 1ps

// Bounded double-ended queue in a ring store, with listing and search.
// Input channel (in_valid / in_stall / in_item): one request per transfer;
//   kind picks insert front/back, remove front/back, list or search.
//   Kinds 6 and 7 are taken and dropped with no result.
// Result channel (out_valid / out_stall / out_item): one result per request,
//   except a listing, which returns one result per stored entry in order
//   from the head; out_item.last marks the final result of each request.
// A two-entry command queue sits between the request decoder and the
// store sequencer, so requests keep being taken while results are held.
// Inserts and empty/full cases answer straight from the idle state;
//   removes, lists and searches walk the store through its single read
//   port, one entry per cycle while the receiver does not stall: a search
//   stops at its first hit, while a miss or a listing walks every entry.
// The sequencer takes the next command only once it is idle again.
// Reset (rst_n low at a clock edge) empties the queue; store contents need
// no clearing. When the receiver stalls, the current result holds and the
// sequencer waits; once the command queue fills, in_stall rises.

module ring_deque_with_search_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rdq_pkg::rdq_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output rdq_pkg::rdq_out_t out_item
);

  logic              cmd_valid;
  logic              cmd_pop;
  rdq_pkg::rdq_cmd_t cmd;

  rdq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  rdq_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
